// ===== rtl/ffba_pkg.sv =====
// Package: command, status and merge codes, word types and the FSM state type.
package ffba_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_WAS_FREE  = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MRG_NONE = 2'd0,
    MRG_BOTH = 2'd1,
    MRG_NEXT = 2'd2,
    MRG_PREV = 2'd3
  } merge_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] req_bytes;
    logic [11:0] block_addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_addr;
    logic [1:0]  merge_kind;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPL,
    S_A_LNK,
    S_F_RD,
    S_F_CHK,
    S_F_RDN,
    S_F_RDP,
    S_F_DEC,
    S_F_W1,
    S_F_W2,
    S_F_W3,
    S_F_W4,
    S_F_W5,
    S_F_W6,
    S_RESP
  } state_t;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit block allocator: header chain kept in one synchronous memory.
//
// Input channel in_valid/in_ready/in_word carries one command: allocate
// (req_bytes payload bytes) or free (header at block_addr). The result
// channel out_valid/out_ready/out_word returns exactly one word per command:
// status, the allocated header offset and, for free, the merge performed.
// Headers live in a memory with one entry per byte offset (POOL_BYTES
// entries), one read or one write per cycle, with registered read data.
// Allocate walks the chain one header at a time (read, check), then gives
// the result; a split adds writes of the chosen header and the remainder
// and a patch of the following header. Free does up to five header reads
// and four header writes. The block returns to idle, with in_ready high,
// after each result. One command is in flight at a time. The result sits
// in an output register; the next command is taken while that word waits,
// and the block then holds its own result until out_ready frees the register.
// After reset a clearing pass writes every memory entry invalid, then lays
// down the initial free block and the sentinel, all with in_ready low.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int SW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [AW-1:0] SENT = AW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [SW-1:0] HDR  = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] HDR2 = SW'(2 * HEADER_BYTES);

  // header: valid, free, size, next, prev
  typedef struct packed {
    logic          valid;
    logic          free;
    logic [SW-1:0] size;
    logic [AW-1:0] next;
    logic [AW-1:0] prev;
  } hdr_t;

  hdr_t mem [POOL_BYTES];

  state_t        state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  in_word_t      req_r, req_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  hdr_t          cur_h_r, cur_h_nxt;
  hdr_t          nb_h_r, nb_h_nxt;
  logic          nf_r, nf_nxt, pf_r, pf_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [11:0]   res_ad_r, res_ad_nxt;
  logic [1:0]    res_mk_r, res_mk_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     ow_r, ow_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  hdr_t          wdata, rdata;

  logic [SW-1:0] want;
  logic [SW-1:0] rem_sz;
  logic [AW-1:0] rem_at;
  logic [AW-1:0] d_at;

  // header memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  assign want   = SW'(req_r.req_bytes);
  assign rem_sz = cur_h_r.size - want;
  assign rem_at = cur_r + AW'(HDR) + AW'(want);
  assign d_at   = nb_h_r.next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    cur_r    <= cur_nxt;
    cur_h_r  <= cur_h_nxt;
    nb_h_r   <= nb_h_nxt;
    nf_r     <= nf_nxt;
    pf_r     <= pf_nxt;
    res_st_r <= res_st_nxt;
    res_ad_r <= res_ad_nxt;
    res_mk_r <= res_mk_nxt;
    ow_r     <= ow_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_word  = ow_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    req_nxt    = req_r;
    cur_nxt    = cur_r;
    cur_h_nxt  = cur_h_r;
    nb_h_nxt   = nb_h_r;
    nf_nxt     = nf_r;
    pf_nxt     = pf_r;
    res_st_nxt = res_st_r;
    res_ad_nxt = res_ad_r;
    res_mk_nxt = res_mk_r;
    ov_nxt     = ov_r;
    ow_nxt     = ow_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = '0;
    raddr      = '0;
    wdata      = '0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SW'(POOL_BYTES - 1)) state_nxt = S_INIT0;
      end
      S_INIT0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{valid: 1'b1, free: 1'b1, size: SW'(POOL_BYTES) - HDR2,
                  next: SENT, prev: SENT};
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        we    = 1'b1;
        waddr = SENT;
        wdata = '{valid: 1'b1, free: 1'b0, size: '0, next: '0, prev: '0};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_word;
          res_st_nxt = ST_DONE;
          res_ad_nxt = '0;
          res_mk_nxt = MRG_NONE;
          if (in_word.cmd == CMD_ALLOC) begin
            cur_nxt   = '0;
            state_nxt = S_A_RD;
          end else begin
            cur_nxt   = AW'(in_word.block_addr);
            state_nxt = S_F_RD;
          end
        end
      end
      // allocate: walk the chain
      S_A_RD: begin
        if (cur_r >= SENT) begin
          res_st_nxt = ST_NO_FIT;
          state_nxt  = S_RESP;
        end else begin
          re        = 1'b1;
          raddr     = cur_r;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        cur_h_nxt = rdata;
        if (!rdata.valid) begin
          res_st_nxt = ST_NO_FIT;
          state_nxt  = S_RESP;
        end else if (rdata.free && rdata.size >= want) begin
          res_ad_nxt = 12'(cur_r);
          if (rdata.size - want >= HDR) begin
            state_nxt = S_A_SPL;
          end else begin
            we        = 1'b1;
            waddr     = cur_r;
            wdata     = rdata;
            wdata.free = 1'b0;
            state_nxt = S_RESP;
          end
        end else begin
          cur_nxt   = rdata.next;
          state_nxt = S_A_RD;
        end
      end
      S_A_SPL: begin
        // chosen block shrinks and links to the remainder
        we    = 1'b1;
        waddr = cur_r;
        wdata = '{valid: 1'b1, free: 1'b0, size: want, next: rem_at,
                  prev: cur_h_r.prev};
        state_nxt = S_A_LNK;
      end
      S_A_LNK: begin
        we    = 1'b1;
        waddr = rem_at;
        wdata = '{valid: 1'b1, free: 1'b1, size: rem_sz - HDR,
                  next: cur_h_r.next, prev: cur_r};
        // following header's prev is patched next
        cur_nxt   = cur_h_r.next;
        cur_h_nxt.prev = rem_at;
        state_nxt = S_F_W4;
        nb_h_nxt  = '0;
        nf_nxt    = 1'b0;
        pf_nxt    = 1'b0;
      end
      // free: read the block
      S_F_RD: begin
        if (SW'(req_r.block_addr) >= SW'(SENT)) begin
          res_st_nxt = ST_WAS_FREE;
          state_nxt  = S_RESP;
        end else begin
          re        = 1'b1;
          raddr     = cur_r;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        cur_h_nxt = rdata;
        if (!rdata.valid || rdata.free) begin
          res_st_nxt = ST_WAS_FREE;
          state_nxt  = S_RESP;
        end else begin
          re        = 1'b1;
          raddr     = rdata.next;
          state_nxt = S_F_RDN;
        end
      end
      S_F_RDN: begin
        nb_h_nxt  = rdata;
        nf_nxt    = rdata.valid && rdata.free;
        re        = 1'b1;
        raddr     = cur_h_r.prev;
        state_nxt = S_F_RDP;
      end
      S_F_RDP: begin
        pf_nxt    = rdata.valid && rdata.free;
        state_nxt = S_F_DEC;
      end
      S_F_DEC: begin
        // d = next of the next block when that one merges
        if (nf_r && pf_r) begin
          res_mk_nxt = MRG_BOTH;
          state_nxt  = S_F_W1;
        end else if (nf_r) begin
          res_mk_nxt = MRG_NEXT;
          we    = 1'b1;
          waddr = cur_r;
          wdata = '{valid: 1'b1, free: 1'b1,
                    size: SW'(d_at) - SW'(cur_r) - HDR,
                    next: d_at, prev: cur_h_r.prev};
          state_nxt = S_F_W2;
        end else if (pf_r) begin
          res_mk_nxt = MRG_PREV;
          state_nxt  = S_F_W1;
        end else begin
          res_mk_nxt = MRG_NONE;
          we    = 1'b1;
          waddr = cur_r;
          wdata = cur_h_r;
          wdata.free = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_F_W1: begin
        // fetch the prev header again so its own prev link is kept
        re        = 1'b1;
        raddr     = cur_h_r.prev;
        state_nxt = S_F_W3;
      end
      S_F_W3: begin
        // rewrite prev header with its real prev link, drop b
        we    = 1'b1;
        waddr = cur_h_r.prev;
        wdata = rdata;
        if (nf_r) begin
          wdata.next = d_at;
          wdata.size = SW'(d_at) - SW'(cur_h_r.prev) - HDR;
        end else begin
          wdata.next = cur_h_r.next;
          wdata.size = SW'(cur_h_r.next) - SW'(cur_h_r.prev) - HDR;
        end
        wdata.free = 1'b1;
        state_nxt  = S_F_W2;
      end
      S_F_W2: begin
        // invalidate the header that vanished
        we    = 1'b1;
        if (nf_r) begin
          waddr = cur_h_r.next;
        end else begin
          waddr = cur_r;
        end
        wdata = '0;
        if (nf_r && pf_r) begin
          cur_nxt        = d_at;
          cur_h_nxt.prev = cur_h_r.prev;
          state_nxt      = S_F_W5;
        end else if (nf_r) begin
          cur_nxt        = d_at;
          cur_h_nxt.prev = cur_r;
          state_nxt      = S_F_W4;
        end else begin
          cur_nxt        = cur_h_r.next;
          cur_h_nxt.prev = cur_h_r.prev;
          state_nxt      = S_F_W4;
        end
      end
      S_F_W5: begin
        // both-merge: b is gone too
        we    = 1'b1;
        waddr = AW'(req_r.block_addr);
        wdata = '0;
        state_nxt = S_F_W4;
      end
      S_F_W4: begin
        // patch prev link of header at cur_r to cur_h_r.prev
        re        = 1'b1;
        raddr     = cur_r;
        state_nxt = S_F_W6;
      end
      S_F_W6: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = rdata;
        wdata.prev = cur_h_r.prev;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ow_nxt = '{status: res_st_r, result_addr: res_ad_r,
                     merge_kind: res_mk_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n) !(we && re))
    else $error("memory read and write in one cycle");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("result word changed while stalled");
  a_alloc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_DONE) |-> out_word.result_addr == '0)
    else $error("address on failed request");

endmodule

// ===== test/tb_first_fit_block_allocator.sv =====
// Testbench for the first-fit block allocator: directed table, then random alloc/free traffic.
module tb_first_fit_block_allocator
  import ffba_pkg::*;
();

  localparam int POOL   = 4096;
  localparam int HDR    = 32;
  localparam int SENT   = POOL - HDR;
  localparam int N_RAND = 1830;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  first_fit_block_allocator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // Shadow of the header chain
  bit          hv [POOL];
  bit          hf [POOL];
  int unsigned hs [POOL];
  int unsigned hn [POOL];
  int unsigned hp [POOL];

  out_word_t   pending_words[$];
  logic [11:0] live_blocks[$];
  int          err_count = 0;

  typedef struct {
    cmd_t        cmd;
    logic [11:0] cnt;
    logic [11:0] addr;
    bit          typed;
    out_word_t   exp;
  } row_t;

  row_t dir_rows[] = '{
    '{CMD_ALLOC, 12'd4095, 12'd0,    1, '{ST_NO_FIT,   12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd4033, 12'd0,    1, '{ST_NO_FIT,   12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd0,    12'd0,    1, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'(SENT), 1, '{ST_WAS_FREE, 12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd4095, 1, '{ST_WAS_FREE, 12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd7,    1, '{ST_WAS_FREE, 12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd32,   1, '{ST_WAS_FREE, 12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd0,    1, '{ST_DONE,     12'd0, MRG_NEXT}},
    // exact fit of the whole pool
    '{CMD_ALLOC, 12'd4032, 12'd0,    1, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd1,    12'd0,    1, '{ST_NO_FIT,   12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd4095, 12'd0,    1, '{ST_DONE,     12'd0, MRG_NONE}},
    // remainder too small for a header: no split
    '{CMD_ALLOC, 12'd4010, 12'd0,    1, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd0,    1, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd100,  12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd100,  12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd100,  12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_ALLOC, 12'd100,  12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd132,  0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd396,  0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd264,  0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}},
    '{CMD_FREE,  12'd0,    12'd0,    0, '{ST_DONE,     12'd0, MRG_NONE}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    err_count++;
  endtask

  function automatic bit chain_free(int unsigned off);
    return off < POOL && hv[off] && hf[off];
  endfunction

  function automatic void chain_reset();
    for (int i = 0; i < POOL; i++) begin
      hv[i] = 0; hf[i] = 0; hs[i] = 0; hn[i] = 0; hp[i] = 0;
    end
    hv[0] = 1; hf[0] = 1; hs[0] = SENT - HDR; hn[0] = SENT; hp[0] = SENT;
    hv[SENT] = 1;
  endfunction

  // First-fit allocate / free-and-coalesce on the shadow chain
  function automatic out_word_t alloc_or_free(in_word_t w);
    out_word_t   r;
    int unsigned cur, want, rem, nx, a, b, c, d;
    bit          pf, nf;
    r = '{ST_DONE, 12'd0, MRG_NONE};
    if (w.cmd == CMD_ALLOC) begin
      want = w.req_bytes;
      cur = 0;
      r.status = ST_NO_FIT;
      for (int steps = 0; steps < POOL; steps++) begin
        if (cur >= SENT || !hv[cur]) break;
        if (hf[cur] && hs[cur] >= want) begin
          hf[cur] = 0;
          if (hs[cur] - want >= HDR) begin
            nx = hn[cur];
            rem = cur + HDR + want;
            hv[rem] = 1; hf[rem] = 1; hp[rem] = cur; hn[rem] = nx;
            hs[rem] = nx - rem - HDR;
            if (nx < POOL) hp[nx] = rem;
            hn[cur] = rem;
            hs[cur] = want;
          end
          r.status = ST_DONE;
          r.result_addr = cur[11:0];
          break;
        end
        cur = hn[cur];
      end
    end else begin
      b = w.block_addr;
      if (b >= SENT || !hv[b] || hf[b]) begin
        r.status = ST_WAS_FREE;
      end else begin
        a = hp[b];
        c = hn[b];
        nf = chain_free(c);
        pf = chain_free(a);
        d = nf ? hn[c] : 0;
        if (nf && pf) begin
          hn[a] = d;
          if (d < POOL) hp[d] = a;
          hs[a] = d - a - HDR;
          hv[b] = 0; hv[c] = 0;
          r.merge_kind = MRG_BOTH;
        end else if (nf) begin
          hn[b] = d;
          if (d < POOL) hp[d] = b;
          hf[b] = 1;
          hs[b] = d - b - HDR;
          hv[c] = 0;
          r.merge_kind = MRG_NEXT;
        end else if (pf) begin
          hn[a] = c;
          if (c < POOL) hp[c] = a;
          hs[a] = c - a - HDR;
          hv[b] = 0;
          r.merge_kind = MRG_PREV;
        end else begin
          hf[b] = 1;
        end
      end
    end
    return r;
  endfunction

  // Drive one word; returns after the edge that accepts it, valid still high
  task automatic send_word(input in_word_t w, output out_word_t pred);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pred = alloc_or_free(w);
    pending_words.push_back(pred);
    if (w.cmd == CMD_ALLOC && pred.status == ST_DONE)
      live_blocks.push_back(pred.result_addr);
    if (w.cmd == CMD_FREE && pred.status == ST_DONE) begin
      for (int i = 0; i < live_blocks.size(); i++)
        if (live_blocks[i] == w.block_addr) begin
          live_blocks.delete(i);
          break;
        end
    end
  endtask

  // Sender burst control: after an accepted word, maybe drop valid for a gap
  int burst_left;
  bit gaps_on;
  task automatic after_word();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver stall pattern: phases of always-ready, coin-flip and rare-ready
  int rx_cycle;
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycle  <= 0;
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 300) % 3)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Result checker, sampled mid-cycle
  always @(negedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, status", int'(out_word.status), -1);
      end else begin
        e = pending_words.pop_front();
        if (out_word.status !== e.status)
          report_mismatch("status", int'(out_word.status), int'(e.status));
        if (out_word.result_addr !== e.result_addr)
          report_mismatch("result_addr", int'(out_word.result_addr),
                          int'(e.result_addr));
        if (out_word.merge_kind !== e.merge_kind)
          report_mismatch("merge_kind", int'(out_word.merge_kind),
                          int'(e.merge_kind));
      end
    end
  end

  // Stimulus
  initial begin
    in_word_t  w;
    out_word_t pred;
    int        pick, idx, waited;
    burst_left = 0;
    gaps_on    = 1;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    chain_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      w = '{dir_rows[i].cmd, dir_rows[i].cnt, dir_rows[i].addr};
      send_word(w, pred);
      if (dir_rows[i].typed && pred !== dir_rows[i].exp)
        report_mismatch("table row predict", int'(pred), int'(dir_rows[i].exp));
      after_word();
    end

    // Random traffic: mostly well-formed alloc/free, some noise
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 400 == 0) gaps_on = $urandom_range(0, 3) != 0;
      w.req_bytes  = 12'($urandom);
      w.block_addr = 12'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        w.cmd = CMD_ALLOC;
        if ($urandom_range(0, 9) != 0) w.req_bytes = 12'($urandom_range(0, 300));
      end else if (pick < 90 && live_blocks.size() > 0) begin
        w.cmd = CMD_FREE;
        idx = $urandom_range(0, live_blocks.size() - 1);
        w.block_addr = live_blocks[idx];
      end else begin
        // noise: random offset, random header-aligned offset or the sentinel
        w.cmd = CMD_FREE;
        if (pick % 3 == 0) w.block_addr = 12'(SENT);
        else if (pick % 3 == 1) w.block_addr = 12'(HDR * $urandom_range(0, POOL / HDR - 1));
      end
      send_word(w, pred);
      after_word();
    end
    in_valid <= 1'b0;

    // Drain
    waited = 0;
    while (pending_words.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
